// ----- rtl/chbd_pkg.sv -----
// Shared types, constants and helper functions for the chunked body decoder.
// No dependencies; imported by chbd_step and http_chunked_body_decoder_core.
`default_nettype none

package chbd_pkg;

    // Default width of the chunk size accumulator and byte counter.
    localparam int SIZE_BITS_DEF = 32;

    // Line framing characters.
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Bytes skipped after each chunk's payload.
    localparam logic [1:0] TRAILER_LEN = 2'd2;

    // Decoder phase.
    typedef enum logic [1:0] {
        PH_SIZE    = 2'd0,
        PH_DATA    = 2'd1,
        PH_TRAILER = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    // One result word as it leaves the decoder.
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       chunk_last;
        logic       body_done;
    } t_result;

    // Decoded hex digit with a flag that says whether the byte was one.
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    // Map an ASCII byte to its hex digit value, if it is one.
    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h41 + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/chbd_step.sv -----
// Next-state and result logic of the chunked body decoder for one byte.
// Depends on chbd_pkg for the phase type, result struct and hex decoding.
`default_nettype none

module chbd_step #(
    parameter int SIZE_BITS = chbd_pkg::SIZE_BITS_DEF
) (
    input  wire logic                 i_chunked_mode,
    input  wire logic [7:0]           i_in_byte,
    input  wire logic                 i_body_start,
    input  wire chbd_pkg::t_phase     i_phase,
    input  wire logic [SIZE_BITS-1:0] i_size_acc,
    input  wire logic [SIZE_BITS-1:0] i_bytes_left,
    input  wire logic                 i_prev_cr,
    input  wire logic                 i_hex_stopped,
    input  wire logic [1:0]           i_trailer_left,
    output chbd_pkg::t_phase          o_phase,
    output logic [SIZE_BITS-1:0]      o_size_acc,
    output logic [SIZE_BITS-1:0]      o_bytes_left,
    output logic                      o_prev_cr,
    output logic                      o_hex_stopped,
    output logic [1:0]                o_trailer_left,
    output chbd_pkg::t_result         o_result
);
    import chbd_pkg::*;

    t_phase                 phase_c;
    logic [SIZE_BITS-1:0]   acc_c;
    logic [SIZE_BITS-1:0]   left_c;
    logic                   cr_c;
    logic                   stop_c;
    logic [1:0]             trl_c;
    logic [SIZE_BITS-1:0]   left_dec;
    logic [1:0]             trl_dec;
    t_hex                   hex;

    // A body start clears the decoder before the byte is handled.
    always_comb begin
        phase_c = i_body_start ? PH_SIZE : i_phase;
        acc_c   = i_body_start ? '0 : i_size_acc;
        left_c  = i_body_start ? '0 : i_bytes_left;
        cr_c    = i_body_start ? 1'b0 : i_prev_cr;
        stop_c  = i_body_start ? 1'b0 : i_hex_stopped;
        trl_c   = i_body_start ? 2'd0 : i_trailer_left;
    end

    // Counters that stop at zero.
    assign left_dec = (left_c != '0) ? left_c - SIZE_BITS'(1) : left_c;
    assign trl_dec  = (trl_c != 2'd0) ? trl_c - 2'd1 : trl_c;
    assign hex      = hex_value(i_in_byte);

    // Phase handling for one byte.
    always_comb begin
        o_phase        = phase_c;
        o_size_acc     = acc_c;
        o_bytes_left   = left_c;
        o_prev_cr      = cr_c;
        o_hex_stopped  = stop_c;
        o_trailer_left = trl_c;
        o_result       = '0;

        if (!i_chunked_mode) begin
            o_result.payload_valid = 1'b1;
            o_result.payload_byte  = i_in_byte;
        end else begin
            unique case (phase_c)
                PH_SIZE: begin
                    if (cr_c && i_in_byte == CH_LF) begin
                        // End of the size line: zero size ends the body.
                        if (acc_c == '0) begin
                            o_phase = PH_DONE;
                        end else begin
                            o_bytes_left = acc_c;
                            o_phase      = PH_DATA;
                        end
                        o_prev_cr = 1'b0;
                    end else begin
                        // Leading hex digits accumulate and saturate.
                        if (!stop_c && hex.ok) begin
                            if (acc_c[SIZE_BITS-1 -: 4] != 4'd0) begin
                                o_size_acc = '1;
                            end else begin
                                o_size_acc = {acc_c[SIZE_BITS-5:0], hex.value};
                            end
                        end else begin
                            o_hex_stopped = 1'b1;
                        end
                        o_prev_cr = (i_in_byte == CH_CR);
                    end
                end
                PH_DATA: begin
                    o_result.payload_valid = 1'b1;
                    o_result.payload_byte  = i_in_byte;
                    o_bytes_left           = left_dec;
                    if (left_dec == '0) begin
                        o_result.chunk_last = 1'b1;
                        o_phase             = PH_TRAILER;
                        o_trailer_left      = TRAILER_LEN;
                    end
                end
                PH_TRAILER: begin
                    // The bytes after the payload are dropped unchecked.
                    o_trailer_left = trl_dec;
                    if (trl_dec == 2'd0) begin
                        o_phase       = PH_SIZE;
                        o_size_acc    = '0;
                        o_prev_cr     = 1'b0;
                        o_hex_stopped = 1'b0;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
        end

        o_result.body_done = i_chunked_mode && (o_phase == PH_DONE);
    end

endmodule

`default_nettype wire

// ----- rtl/http_chunked_body_decoder_core.sv -----
// Top level of the HTTP chunked transfer body decoder with stream ports.
// Depends on chbd_pkg and instantiates chbd_step.
`default_nettype none

// The decoder takes one body byte per clock on the slave stream while the
// output register is empty or being drained, and returns exactly one word
// per byte on the master stream in the cycle after the byte is accepted.
// Each word carries the byte with a valid flag, marks the last byte of a
// chunk on tlast, and flags the end of the body. The only storage is the
// chunked_mode register, the decoder state and one output register. The
// chunked_mode register is written through i_cfg_we and i_cfg_wdata and
// takes effect on the next byte.

module http_chunked_body_decoder_core #(
    parameter int SIZE_BITS = chbd_pkg::SIZE_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration write: chunked_mode.
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,
    // Input stream.
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tuser,   // [0] body_start
    // Output stream.
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] payload_byte
    output logic            m_axis_tlast,   // chunk_last
    output logic [1:0]      m_axis_tuser    // [0] payload_valid, [1] body_done
);
    import chbd_pkg::*;

    logic                   r_chunked_mode;
    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [SIZE_BITS-1:0]   r_size_acc;
    logic [SIZE_BITS-1:0]   n_size_acc;
    logic [SIZE_BITS-1:0]   r_bytes_left;
    logic [SIZE_BITS-1:0]   n_bytes_left;
    logic                   r_prev_cr;
    logic                   n_prev_cr;
    logic                   r_hex_stopped;
    logic                   n_hex_stopped;
    logic [1:0]             r_trailer_left;
    logic [1:0]             n_trailer_left;
    logic                   r_out_valid;
    t_result                r_result;
    t_result                n_result;
    logic                   in_accept;

    // The output register frees up when it is empty or drained this cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Per-byte decode.
    chbd_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .i_chunked_mode (r_chunked_mode),
        .i_in_byte      (s_axis_tdata),
        .i_body_start   (s_axis_tuser),
        .i_phase        (r_phase),
        .i_size_acc     (r_size_acc),
        .i_bytes_left   (r_bytes_left),
        .i_prev_cr      (r_prev_cr),
        .i_hex_stopped  (r_hex_stopped),
        .i_trailer_left (r_trailer_left),
        .o_phase        (n_phase),
        .o_size_acc     (n_size_acc),
        .o_bytes_left   (n_bytes_left),
        .o_prev_cr      (n_prev_cr),
        .o_hex_stopped  (n_hex_stopped),
        .o_trailer_left (n_trailer_left),
        .o_result       (n_result)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunked_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_chunked_mode <= i_cfg_wdata;
        end
    end

    // Decoder state advances on every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SIZE;
            r_size_acc     <= '0;
            r_bytes_left   <= '0;
            r_prev_cr      <= 1'b0;
            r_hex_stopped  <= 1'b0;
            r_trailer_left <= 2'd0;
        end else if (in_accept) begin
            r_phase        <= n_phase;
            r_size_acc     <= n_size_acc;
            r_bytes_left   <= n_bytes_left;
            r_prev_cr      <= n_prev_cr;
            r_hex_stopped  <= n_hex_stopped;
            r_trailer_left <= n_trailer_left;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_result.payload_byte;
    assign m_axis_tlast  = r_result.chunk_last;
    assign m_axis_tuser  = {r_result.body_done, r_result.payload_valid};

endmodule

`default_nettype wire
